/* rtl/ccit_pkg.sv */
// Package with shared constants and codes of the conditional count inference table.
`default_nettype none
package ccit_pkg;

  localparam int NUM_ACTIONS_DEF = 16;
  localparam int MAX_DEPS_DEF    = 4;
  localparam int COUNT_BITS_DEF  = 32;

  localparam int ID_W   = 16;
  localparam int SLOT_W = 4;
  localparam int POS_W  = 2;
  localparam int DCNT_W = 3;
  localparam int FRAC_W = 16;
  localparam int PROB_W = 17;

  localparam logic [PROB_W-1:0] ONE_Q16 = PROB_W'(1) << FRAC_W;

  typedef enum logic [1:0] {
    OP_DEFINE = 2'd0,
    OP_DEPEND = 2'd1,
    OP_UPDATE = 2'd2,
    OP_INFER  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NOT_FOUND  = 2'd1,
    ST_ZERO_TOTAL = 2'd2
  } status_e;

endpackage
`default_nettype wire

/* rtl/ccit_if.sv */
// Valid/ready channel interfaces for the input and result words of the table.
`default_nettype none
interface ccit_in_if;
  logic                             valid;
  logic                             ready;
  ccit_pkg::op_e                    operation;
  logic [ccit_pkg::SLOT_W-1:0]      slot;
  logic [ccit_pkg::ID_W-1:0]        action_id;
  logic [ccit_pkg::POS_W-1:0]       dep_position;
  logic [ccit_pkg::DCNT_W-1:0]      dep_count;
  logic [ccit_pkg::ID_W-1:0]        item_id;
  logic                             evidence_valid;
  logic                             last;

  modport source (output valid, operation, slot, action_id, dep_position, dep_count,
                  item_id, evidence_valid, last, input ready);
  modport sink (input valid, operation, slot, action_id, dep_position, dep_count,
                item_id, evidence_valid, last, output ready);
endinterface

interface ccit_out_if;
  logic                          valid;
  logic                          ready;
  logic [ccit_pkg::PROB_W-1:0]   probability;
  ccit_pkg::status_e             status;
  logic                          was_infer;

  modport source (output valid, probability, status, was_infer, input ready);
  modport sink (input valid, probability, status, was_infer, output ready);
endinterface
`default_nettype wire

/* rtl/ccit_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module ccit_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                                          clk_i,
  input  wire logic                                          we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr_i,
  input  wire logic [WIDTH-1:0]                              wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr_i,
  output logic      [WIDTH-1:0]                              rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

/* rtl/conditional_count_inference_table_unit.sv */
// Top level of the conditional count inference table: sequencer around four RAMs.
// Define: accept the word, then clear the slot's occurrence and subset counts.
// Set dependency: the same. Update/infer words: accept, then walk the slots in order up
// to the matching one, reading metadata only for valid slots, then compare each
// dependency when evidence is valid; a last word reads the counts, runs the divider
// on an infer whose ratio is below one, and loads the result register, which waits while
// an earlier result is held. One word is handled at a time.
// Reset clears all slot valid bits, the total count and the run's subset bits.
`default_nettype none
module conditional_count_inference_table_unit #(
  parameter int NUM_ACTIONS = ccit_pkg::NUM_ACTIONS_DEF,
  parameter int MAX_DEPS    = ccit_pkg::MAX_DEPS_DEF,
  parameter int COUNT_BITS  = ccit_pkg::COUNT_BITS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ccit_in_if.sink    in_i,
  ccit_out_if.source out_o
);
  // Derived widths. Slot and position indexes are padded to powers of two so
  // that dependency and subset addresses are plain concatenations.
  localparam int SW      = (NUM_ACTIONS > 1) ? $clog2(NUM_ACTIONS) : 1;
  localparam int IW      = SW + 1;
  localparam int JW      = (MAX_DEPS > 1) ? $clog2(MAX_DEPS) : 1;
  localparam int JCW     = JW + 1;
  localparam int DCW     = $clog2(MAX_DEPS + 1);
  localparam int CB      = COUNT_BITS;
  localparam int META_W  = ccit_pkg::ID_W + DCW;
  localparam int DDEPTH  = (1 << SW) * (1 << JW);
  localparam int SDEPTH  = (1 << SW) * (1 << MAX_DEPS);
  localparam int DAW     = SW + JW;
  localparam int SAW     = SW + MAX_DEPS;
  localparam int FW      = ccit_pkg::FRAC_W;
  localparam int PW      = ccit_pkg::PROB_W;
  localparam int STEP_W  = $clog2(FW);

  // Sequencer states, one-hot.
  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_CLR  = 11'b00000000010,
    S_SRD  = 11'b00000000100,
    S_SCHK = 11'b00000001000,
    S_DRD  = 11'b00000010000,
    S_DCHK = 11'b00000100000,
    S_CRD  = 11'b00001000000,
    S_CUPD = 11'b00010000000,
    S_DIV  = 11'b00100000000,
    S_RES  = 11'b01000000000,
    S_SPARE = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  // Latched word.
  ccit_pkg::op_e             op_q, op_d;
  logic [ccit_pkg::ID_W-1:0] aid_q, aid_d;
  logic [ccit_pkg::ID_W-1:0] item_q, item_d;
  logic                      ev_q, ev_d;
  logic                      last_q, last_d;

  // Working registers.
  logic [SW-1:0]        slot_q, slot_d;
  logic [IW-1:0]        idx_q, idx_d;
  logic [JCW-1:0]       j_q, j_d;
  logic [DCW-1:0]       dcnt_q, dcnt_d;
  logic [MAX_DEPS-1:0]  bits_q, bits_d;
  logic [MAX_DEPS-1:0]  k_q, k_d;
  logic [NUM_ACTIONS-1:0] valid_q, valid_d;
  logic [CB-1:0]        total_q, total_d;
  logic [CB:0]          rem_q, rem_d;
  logic [CB-1:0]        den_q, den_d;
  logic [STEP_W-1:0]    step_q, step_d;
  logic [PW-1:0]        prob_q, prob_d;
  ccit_pkg::status_e    stat_q, stat_d;

  // Result register.
  logic                 out_valid_q, out_valid_d;
  logic [PW-1:0]        out_prob_q, out_prob_d;
  ccit_pkg::status_e    out_stat_q, out_stat_d;
  logic                 out_infer_q, out_infer_d;

  // RAM ports.
  logic               meta_we;
  logic [SW-1:0]      meta_waddr, meta_raddr;
  logic [META_W-1:0]  meta_wdata, meta_rdata;
  logic               dep_we;
  logic [DAW-1:0]     dep_waddr, dep_raddr;
  logic [ccit_pkg::ID_W-1:0] dep_wdata, dep_rdata;
  logic               occ_we;
  logic [SW-1:0]      occ_waddr, occ_raddr;
  logic [CB-1:0]      occ_wdata, occ_rdata;
  logic               sub_we;
  logic [SAW-1:0]     sub_waddr, sub_raddr;
  logic [CB-1:0]      sub_wdata, sub_rdata;

  logic in_accept;
  logic slot_ok;
  logic pos_ok;
  logic [DCW-1:0] dcnt_clamped;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_accept  = in_i.valid && in_i.ready;
  assign slot_ok    = ({5'b0, in_i.slot} < 9'(NUM_ACTIONS));
  assign pos_ok     = ({2'b0, in_i.dep_position} < 4'(MAX_DEPS));
  assign dcnt_clamped = ({1'b0, in_i.dep_count} > 4'(MAX_DEPS)) ? DCW'(MAX_DEPS)
                                                                 : DCW'(in_i.dep_count);

  // Slot metadata: action id and clamped dependency count.
  ccit_ram #(.WIDTH(META_W), .DEPTH(1 << SW)) u_meta_ram (
    .clk_i  (clk_i),
    .we_i   (meta_we),
    .waddr_i(meta_waddr),
    .wdata_i(meta_wdata),
    .raddr_i(meta_raddr),
    .rdata_o(meta_rdata)
  );

  // Dependency ids, addressed by {slot, position}.
  ccit_ram #(.WIDTH(ccit_pkg::ID_W), .DEPTH(DDEPTH)) u_dep_ram (
    .clk_i  (clk_i),
    .we_i   (dep_we),
    .waddr_i(dep_waddr),
    .wdata_i(dep_wdata),
    .raddr_i(dep_raddr),
    .rdata_o(dep_rdata)
  );

  // Occurrence count per slot.
  ccit_ram #(.WIDTH(CB), .DEPTH(1 << SW)) u_occ_ram (
    .clk_i  (clk_i),
    .we_i   (occ_we),
    .waddr_i(occ_waddr),
    .wdata_i(occ_wdata),
    .raddr_i(occ_raddr),
    .rdata_o(occ_rdata)
  );

  // Subset counts, addressed by {slot, subset bits}.
  ccit_ram #(.WIDTH(CB), .DEPTH(SDEPTH)) u_sub_ram (
    .clk_i  (clk_i),
    .we_i   (sub_we),
    .waddr_i(sub_waddr),
    .wdata_i(sub_wdata),
    .raddr_i(sub_raddr),
    .rdata_o(sub_rdata)
  );

  // Main sequencer. Every RAM access is issued in one state and consumed in
  // the next, and no write is ever followed by a read of the same entry
  // before the write has landed, so no forwarding path is needed.
  always_comb begin
    logic [CB-1:0] num_v;
    logic [CB-1:0] den_v;
    logic          div_go_v;
    logic [CB:0]   rem2_v;

    state_d  = state_q;
    op_d     = op_q;
    aid_d    = aid_q;
    item_d   = item_q;
    ev_d     = ev_q;
    last_d   = last_q;
    slot_d   = slot_q;
    idx_d    = idx_q;
    j_d      = j_q;
    dcnt_d   = dcnt_q;
    bits_d   = bits_q;
    k_d      = k_q;
    valid_d  = valid_q;
    total_d  = total_q;
    rem_d    = rem_q;
    den_d    = den_q;
    step_d   = step_q;
    prob_d   = prob_q;
    stat_d   = stat_q;
    out_valid_d = out_valid_q;
    out_prob_d  = out_prob_q;
    out_stat_d  = out_stat_q;
    out_infer_d = out_infer_q;

    num_v    = '0;
    den_v    = '0;
    div_go_v = 1'b0;
    rem2_v   = {rem_q[CB-1:0], 1'b0};

    meta_we    = 1'b0;
    meta_waddr = SW'(in_i.slot);
    meta_wdata = {dcnt_clamped, in_i.action_id};
    meta_raddr = idx_q[SW-1:0];
    dep_we     = 1'b0;
    dep_waddr  = {SW'(in_i.slot), JW'(in_i.dep_position)};
    dep_wdata  = in_i.item_id;
    dep_raddr  = {slot_q, j_q[JW-1:0]};
    occ_we     = 1'b0;
    occ_waddr  = slot_q;
    occ_wdata  = '0;
    occ_raddr  = slot_q;
    sub_we     = 1'b0;
    sub_waddr  = {slot_q, k_q};
    sub_wdata  = '0;
    sub_raddr  = {slot_q, bits_q};

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          op_d   = in_i.operation;
          aid_d  = in_i.action_id;
          item_d = in_i.item_id;
          ev_d   = in_i.evidence_valid;
          last_d = in_i.last;
          k_d    = '0;
          idx_d  = '0;
          case (in_i.operation)
            ccit_pkg::OP_DEFINE: begin
              if (slot_ok) begin
                meta_we = 1'b1;
                valid_d[SW'(in_i.slot)] = 1'b1;
                slot_d  = SW'(in_i.slot);
                state_d = S_CLR;
              end
            end
            ccit_pkg::OP_DEPEND: begin
              if (slot_ok && pos_ok) begin
                dep_we  = 1'b1;
                slot_d  = SW'(in_i.slot);
                state_d = S_CLR;
              end
            end
            default: begin
              state_d = S_SRD;
            end
          endcase
        end
      end

      // Zero the occurrence count and every subset count of the slot.
      S_CLR: begin
        sub_we = 1'b1;
        occ_we = (k_q == '0);
        if (k_q == '1) begin
          state_d = S_IDLE;
        end else begin
          k_d = k_q + 1'b1;
        end
      end

      // Walk the slots in order; only valid ones cost a metadata read.
      S_SRD: begin
        if (idx_q == IW'(NUM_ACTIONS)) begin
          if (last_q) begin
            prob_d  = '0;
            stat_d  = ccit_pkg::ST_NOT_FOUND;
            state_d = S_RES;
          end else begin
            state_d = S_IDLE;
          end
        end else if (valid_q[idx_q[SW-1:0]]) begin
          state_d = S_SCHK;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      S_SCHK: begin
        if (meta_rdata[ccit_pkg::ID_W-1:0] == aid_q) begin
          slot_d = idx_q[SW-1:0];
          dcnt_d = meta_rdata[META_W-1:ccit_pkg::ID_W];
          j_d    = '0;
          if (ev_q) begin
            state_d = S_DRD;
          end else if (last_q) begin
            state_d = S_CRD;
          end else begin
            state_d = S_IDLE;
          end
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_SRD;
        end
      end

      // Compare the evidence id against each dependency of the slot.
      S_DRD: begin
        if (j_q == JCW'(dcnt_q)) begin
          state_d = last_q ? S_CRD : S_IDLE;
        end else begin
          state_d = S_DCHK;
        end
      end

      S_DCHK: begin
        if (dep_rdata == item_q) begin
          bits_d[j_q[JW-1:0]] = 1'b1;
        end
        j_d     = j_q + 1'b1;
        state_d = S_DRD;
      end

      S_CRD: begin
        state_d = S_CUPD;
      end

      S_CUPD: begin
        prob_d = '0;
        stat_d = ccit_pkg::ST_OK;
        if (op_q == ccit_pkg::OP_UPDATE) begin
          occ_we    = 1'b1;
          occ_wdata = (occ_rdata == '1) ? occ_rdata : occ_rdata + 1'b1;
          sub_we    = 1'b1;
          sub_waddr = {slot_q, bits_q};
          sub_wdata = (sub_rdata == '1) ? sub_rdata : sub_rdata + 1'b1;
          total_d   = (total_q == '1) ? total_q : total_q + 1'b1;
          state_d   = S_RES;
        end else if (dcnt_q == '0) begin
          if (total_q == '0) begin
            stat_d  = ccit_pkg::ST_ZERO_TOTAL;
            state_d = S_RES;
          end else begin
            num_v    = occ_rdata;
            den_v    = total_q;
            div_go_v = 1'b1;
          end
        end else if (occ_rdata == '0) begin
          state_d = S_RES;
        end else begin
          num_v    = sub_rdata;
          den_v    = occ_rdata;
          div_go_v = 1'b1;
        end
        if (div_go_v) begin
          if (num_v >= den_v) begin
            prob_d  = ccit_pkg::ONE_Q16;
            state_d = S_RES;
          end else begin
            rem_d   = {1'b0, num_v};
            den_d   = den_v;
            step_d  = '0;
            state_d = S_DIV;
          end
        end
      end

      // Restoring division, one quotient bit per cycle.
      S_DIV: begin
        if (rem2_v >= {1'b0, den_q}) begin
          rem_d  = rem2_v - {1'b0, den_q};
          prob_d = {prob_q[PW-2:0], 1'b1};
        end else begin
          rem_d  = rem2_v;
          prob_d = {prob_q[PW-2:0], 1'b0};
        end
        step_d = step_q + 1'b1;
        if (step_q == '1) begin
          state_d = S_RES;
        end
      end

      S_RES: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_prob_d  = prob_q;
          out_stat_d  = stat_q;
          out_infer_d = (op_q == ccit_pkg::OP_INFER);
          bits_d      = '0;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      total_q     <= '0;
      bits_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      total_q     <= total_d;
      bits_q      <= bits_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    aid_q      <= aid_d;
    item_q     <= item_d;
    ev_q       <= ev_d;
    last_q     <= last_d;
    slot_q     <= slot_d;
    idx_q      <= idx_d;
    j_q        <= j_d;
    dcnt_q     <= dcnt_d;
    k_q        <= k_d;
    rem_q      <= rem_d;
    den_q      <= den_d;
    step_q     <= step_d;
    prob_q     <= prob_d;
    stat_q     <= stat_d;
    out_prob_q <= out_prob_d;
    out_stat_q <= out_stat_d;
    out_infer_q <= out_infer_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.probability = out_prob_q;
  assign out_o.status      = out_stat_q;
  assign out_o.was_infer   = out_infer_q;

  // The divider only runs with a nonzero divisor and a partial remainder below it.
  a_div_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (den_q != '0))
    else $error("divider running with a zero divisor");

  a_div_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q < {1'b0, den_q}))
    else $error("divider remainder not below divisor");

  // An update acknowledge never carries a probability.
  a_ack_zero_prob: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_infer_q) |-> (out_prob_q == '0))
    else $error("update acknowledge with nonzero probability");

  // The run's subset bits are empty whenever a new word is taken after a result.
  a_bits_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RES && state_d == S_IDLE) |=> (bits_q == '0))
    else $error("subset bits not cleared after a result");

endmodule
`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for the conditional count inference table unit.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import ccit_pkg::*;

  // The run is ended by force once this many clock cycles have gone by.
  localparam int CYCLE_LIMIT = 600000;
  // Cycles allowed after the last result for a define still clearing counts.
  localparam int DRAIN_CYCLES = 200;
  localparam int NUM_SLOTS = NUM_ACTIONS_DEF;
  localparam int DEPS = MAX_DEPS_DEF;
  localparam int SUBSETS = 1 << DEPS;

  // One input word as the sender sees it.
  typedef struct {
    op_e               op;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   action;
    logic [POS_W-1:0]  pos;
    logic [DCNT_W-1:0] dcnt;
    logic [ID_W-1:0]   item;
    logic              ev;
    logic              last;
  } word_t;

  // One result word as expected or seen.
  typedef struct {
    logic [PROB_W-1:0] prob;
    status_e           status;
    logic              was_infer;
  } answer_t;

  logic clk_i;
  logic rst_ni;
  ccit_in_if  in_i ();
  ccit_out_if out_o ();

  conditional_count_inference_table_unit uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_i.sink),
    .out_o (out_o.source)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Shadow copy of the table, kept in step with every accepted input word.
  bit              tbl_valid [NUM_SLOTS];
  logic [ID_W-1:0] tbl_action [NUM_SLOTS];
  int unsigned     tbl_ndeps [NUM_SLOTS];
  logic [ID_W-1:0] tbl_dep [NUM_SLOTS][DEPS];
  logic [31:0]     tbl_occ [NUM_SLOTS];
  logic [31:0]     tbl_subset [NUM_SLOTS][SUBSETS];
  logic [31:0]     events_seen;
  logic [DEPS-1:0] evidence_bits;

  answer_t pending_answers[$];
  int      fails;
  int      cycles;
  int      sender_idle_pct;
  int      receiver_stall_pct;

  // Action ids drawn mostly from a small pool so that ids repeat across slots.
  logic [ID_W-1:0] action_pool [8] = '{16'h0000, 16'hFFFF, 16'h1234, 16'h8001,
                                      16'h0042, 16'h7FFE, 16'h5555, 16'hAAAA};
  logic [ID_W-1:0] dep_pool [8] = '{16'h0000, 16'hFFFF, 16'h0001, 16'h0002,
                                   16'h00F0, 16'h8000, 16'h3C3C, 16'hC3C3};

  function automatic logic [31:0] bump(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic logic [PROB_W-1:0] q16_ratio(logic [31:0] num, logic [31:0] den);
    logic [63:0] q;
    q = ({32'd0, num} << FRAC_W) / {32'd0, den};
    return (q > 64'(ONE_Q16)) ? ONE_Q16 : q[PROB_W-1:0];
  endfunction

  function automatic int lookup_slot(logic [ID_W-1:0] id);
    for (int s = 0; s < NUM_SLOTS; s++) begin
      if (tbl_valid[s] && tbl_action[s] == id) return s;
    end
    return -1;
  endfunction

  // Applies one accepted word to the shadow table and queues any result it causes.
  task automatic apply_word(word_t w);
    int s;
    answer_t a;
    s = -1;
    a.prob = '0;
    a.status = ST_OK;
    a.was_infer = (w.op == OP_INFER);
    case (w.op)
      OP_DEFINE: begin
        tbl_valid[w.slot] = 1'b1;
        tbl_action[w.slot] = w.action;
        tbl_ndeps[w.slot] = (w.dcnt > DEPS) ? DEPS : w.dcnt;
        tbl_occ[w.slot] = '0;
        for (int k = 0; k < SUBSETS; k++) tbl_subset[w.slot][k] = '0;
      end
      OP_DEPEND: begin
        tbl_dep[w.slot][w.pos] = w.item;
        tbl_occ[w.slot] = '0;
        for (int k = 0; k < SUBSETS; k++) tbl_subset[w.slot][k] = '0;
      end
      default: begin
        s = lookup_slot(w.action);
        if (w.ev && s >= 0) begin
          for (int j = 0; j < tbl_ndeps[s]; j++) begin
            if (tbl_dep[s][j] == w.item) evidence_bits[j] = 1'b1;
          end
        end
        if (w.last) begin
          if (s < 0) begin
            a.status = ST_NOT_FOUND;
          end else if (w.op == OP_UPDATE) begin
            tbl_occ[s] = bump(tbl_occ[s]);
            events_seen = bump(events_seen);
            tbl_subset[s][evidence_bits] = bump(tbl_subset[s][evidence_bits]);
          end else if (tbl_ndeps[s] == 0) begin
            // A plain prior: share of all recorded events.
            if (events_seen == 0) a.status = ST_ZERO_TOTAL;
            else a.prob = q16_ratio(tbl_occ[s], events_seen);
          end else if (tbl_occ[s] != 0) begin
            a.prob = q16_ratio(tbl_subset[s][evidence_bits], tbl_occ[s]);
          end
          evidence_bits = '0;
          pending_answers.push_back(a);
        end
      end
    endcase
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
    fails++;
  endtask

  // Input monitor: every accepted word feeds the predictor.
  always @(posedge clk_i) begin
    word_t w;
    if (rst_ni && in_i.valid && in_i.ready) begin
      w.op = in_i.operation;
      w.slot = in_i.slot;
      w.action = in_i.action_id;
      w.pos = in_i.dep_position;
      w.dcnt = in_i.dep_count;
      w.item = in_i.item_id;
      w.ev = in_i.evidence_valid;
      w.last = in_i.last;
      apply_word(w);
    end
  end

  // Result checker: each accepted result word against the oldest expectation.
  always @(posedge clk_i) begin
    answer_t a;
    if (rst_ni && out_o.valid && out_o.ready) begin
      if (pending_answers.size() == 0) begin
        $display("unexpected result word at cycle %0d", cycles);
        fails++;
      end else begin
        a = pending_answers.pop_front();
        if (out_o.probability !== a.prob)
          report("probability", 32'(out_o.probability), 32'(a.prob));
        if (out_o.status !== a.status)
          report("status", 32'(out_o.status), 32'(a.status));
        if (out_o.was_infer !== a.was_infer)
          report("was_infer", 32'(out_o.was_infer), 32'(a.was_infer));
      end
    end
  end

  // The receiver stalls at random according to the current phase.
  always @(posedge clk_i) begin
    out_o.ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("conditional_count_inference_table_unit regression: fail");
      $finish;
    end
  end

  // Presents one word and holds it until it is taken. Valid stays high afterward
  // so that back-to-back words need no second assignment in one time step.
  task automatic send_word(word_t w);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_i.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_i.valid <= 1'b1;
    in_i.operation <= w.op;
    in_i.slot <= w.slot;
    in_i.action_id <= w.action;
    in_i.dep_position <= w.pos;
    in_i.dep_count <= w.dcnt;
    in_i.item_id <= w.item;
    in_i.evidence_valid <= w.ev;
    in_i.last <= w.last;
    do @(posedge clk_i); while (!in_i.ready);
  endtask

  function automatic word_t blank_word(op_e op);
    word_t w;
    w.op = op;
    w.slot = '0;
    w.action = '0;
    w.pos = '0;
    w.dcnt = '0;
    w.item = '0;
    w.ev = 1'b0;
    w.last = 1'b0;
    return w;
  endfunction

  task automatic define_slot(int s, logic [ID_W-1:0] id, int n);
    word_t w;
    w = blank_word(OP_DEFINE);
    w.slot = SLOT_W'(s);
    w.action = id;
    w.dcnt = DCNT_W'(n);
    send_word(w);
  endtask

  task automatic set_dep(int s, int p, logic [ID_W-1:0] id);
    word_t w;
    w = blank_word(OP_DEPEND);
    w.slot = SLOT_W'(s);
    w.pos = POS_W'(p);
    w.item = id;
    send_word(w);
  endtask

  // Sends one evidence word of an update or infer run.
  task automatic evidence(op_e op, logic [ID_W-1:0] act, logic [ID_W-1:0] id,
                          logic ev, logic last);
    word_t w;
    w = blank_word(op);
    w.action = act;
    w.item = id;
    w.ev = ev;
    w.last = last;
    // Fields that the operation ignores still carry random bits.
    w.slot = SLOT_W'($urandom_range(15));
    w.pos = POS_W'($urandom_range(3));
    w.dcnt = DCNT_W'($urandom_range(7));
    send_word(w);
  endtask

  function automatic logic [ID_W-1:0] pick_action();
    return ($urandom_range(99) < 85) ? action_pool[$urandom_range(7)] : ID_W'($urandom);
  endfunction

  function automatic logic [ID_W-1:0] pick_dep();
    return ($urandom_range(99) < 80) ? dep_pool[$urandom_range(7)] : ID_W'($urandom);
  endfunction

  // Every dependency id is written once up front, so no run ever looks at an
  // id that was never stored, however slots are redefined later.
  task automatic test_table_load();
    for (int s = 0; s < NUM_SLOTS; s++) begin
      for (int p = 0; p < DEPS; p++) set_dep(s, p, dep_pool[(s + p) % 8]);
    end
  endtask

  task automatic test_directed();
    // A prior before any event was recorded reports a zero total.
    define_slot(0, 16'h0000, 0);
    evidence(OP_INFER, 16'h0000, 16'h0000, 1'b1, 1'b1);
    // An id that is in no slot is reported as not found, for both operations.
    evidence(OP_INFER, 16'h4321, 16'hFFFF, 1'b1, 1'b1);
    evidence(OP_UPDATE, 16'h4321, 16'h0000, 1'b0, 1'b1);
    // A dependency count above the limit is clamped to the limit.
    define_slot(1, 16'hFFFF, 7);
    set_dep(1, 0, 16'h0000);
    set_dep(1, 1, 16'hFFFF);
    set_dep(1, 2, 16'h0001);
    set_dep(1, 3, 16'h8000);
    // A dependent action that was never seen gives zero with good status.
    evidence(OP_INFER, 16'hFFFF, 16'h0000, 1'b1, 1'b1);
    // A duplicate id in a higher slot must never be chosen.
    define_slot(2, 16'h0000, 2);
    evidence(OP_UPDATE, 16'h0000, 16'h0000, 1'b0, 1'b1);
    evidence(OP_UPDATE, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
    evidence(OP_UPDATE, 16'hFFFF, 16'h8000, 1'b1, 1'b0);
    evidence(OP_UPDATE, 16'hFFFF, 16'h1111, 1'b1, 1'b1);
    evidence(OP_UPDATE, 16'hFFFF, 16'h0000, 1'b0, 1'b1);
    // Matching subset, empty subset and a prior after events.
    evidence(OP_INFER, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
    evidence(OP_INFER, 16'hFFFF, 16'h8000, 1'b1, 1'b1);
    evidence(OP_INFER, 16'hFFFF, 16'h0000, 1'b0, 1'b1);
    evidence(OP_INFER, 16'h0000, 16'h0000, 1'b0, 1'b1);
  endtask

  // Random traffic: mostly well-formed runs against known actions, with some
  // table rewrites, mixed action ids inside a run and evidence-free words.
  task automatic test_random(int words, int idle_pct, int stall_pct);
    int sent;
    int len;
    op_e op;
    logic [ID_W-1:0] act;
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    sent = 0;
    while (sent < words) begin
      case ($urandom_range(99)) inside
        [0:7]: begin
          define_slot($urandom_range(15), pick_action(), $urandom_range(7));
          sent++;
        end
        [8:13]: begin
          set_dep($urandom_range(15), $urandom_range(3), pick_dep());
          sent++;
        end
        default: begin
          op = ($urandom_range(99) < 55) ? OP_UPDATE : OP_INFER;
          act = pick_action();
          len = $urandom_range(1, 4);
          for (int k = 0; k < len; k++) begin
            evidence(op, ($urandom_range(99) < 5) ? pick_action() : act, pick_dep(),
                     $urandom_range(99) < 90, k == len - 1);
            sent++;
          end
        end
      endcase
    end
  endtask

  // The sender holds off until every queued result has been delivered.
  task automatic test_quiet_pause();
    in_i.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_answers.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  initial begin
    fails = 0;
    cycles = 0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    events_seen = '0;
    evidence_bits = '0;
    for (int s = 0; s < NUM_SLOTS; s++) tbl_valid[s] = 1'b0;
    rst_ni = 1'b0;
    out_o.ready = 1'b0;
    in_i.valid = 1'b0;
    in_i.operation = OP_DEFINE;
    in_i.slot = '0;
    in_i.action_id = '0;
    in_i.dep_position = '0;
    in_i.dep_count = '0;
    in_i.item_id = '0;
    in_i.evidence_valid = 1'b0;
    in_i.last = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_table_load();
    test_directed();
    test_random(110, 0, 0);
    test_quiet_pause();
    test_random(100, 73, 0);
    test_random(100, 0, 73);
    test_random(110, 26, 26);

    in_i.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fails == 0) begin
      $display("conditional_count_inference_table_unit regression: pass");
    end else begin
      $display("conditional_count_inference_table_unit regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* files.f */
rtl/ccit_pkg.sv
rtl/ccit_if.sv
rtl/ccit_ram.sv
rtl/conditional_count_inference_table_unit.sv
tb/tb_top.sv
